// ===== sv/sbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types and constants of the string template bijection checker.
// ----------------------------------------------------------------------------
package sbc_pkg;

	localparam int MAX_TEMPLATE  = 1024;
	localparam int ALPHABET_SIZE = 26;

	localparam int TIDX_W = $clog2(MAX_TEMPLATE);
	localparam int TCNT_W = $clog2(MAX_TEMPLATE + 1);
	localparam int POS_W  = TCNT_W + 1;
	localparam int LIDX_W = $clog2(ALPHABET_SIZE);
	localparam int LET_W  = 5;
	localparam int VAL_W  = 32;

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_LETTER = 2'd2;

	typedef struct packed {
		logic [1:0]              req_type;
		logic signed [VAL_W-1:0] template_value;
		logic [LET_W-1:0]        letter;
		logic                    last_letter;
	} sbc_in_t;

	typedef struct packed {
		logic matches_res;
		logic length_mismatch;
		logic template_overflow;
	} sbc_out_t;

	// one item's command, decoded at the input handshake
	typedef struct packed {
		logic clr;
		logic app;
		logic chk;
	} sbc_cmd_t;

	// per template position: group id and whether it opens that group
	typedef struct packed {
		logic              is_new;
		logic [TIDX_W-1:0] grp;
	} sbc_pg_t;

	// template store status seen by the letter checker and the top level
	typedef struct packed {
		logic              busy;
		logic              pg_we;
		logic              ovf;
		logic [TCNT_W-1:0] tlen;
	} sbc_tstat_t;

endpackage

// ===== sv/sbc_tmpl_store.sv =====
// ----------------------------------------------------------------------------
// sbc_tmpl_store
// Template memories: group per position and distinct values, with the
// sequential search that assigns group ids on append.
// ----------------------------------------------------------------------------
module sbc_tmpl_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sbc_pkg::sbc_cmd_t         cmd,
	input  logic [sbc_pkg::VAL_W-1:0] value,
	input  logic [sbc_pkg::TIDX_W-1:0] rd_addr,
	output sbc_pkg::sbc_pg_t          pg_rdata,
	output sbc_pkg::sbc_tstat_t       tstat
);
	import sbc_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SRCH = 1'b1;

	logic              state_q, state_d;
	logic [TCNT_W-1:0] tlen_q, tlen_d;
	logic [TCNT_W-1:0] gtot_q, gtot_d;
	logic              ovf_q, ovf_d;
	logic [VAL_W-1:0]  val_q, val_d;
	logic [TIDX_W-1:0] idx_q, idx_d;

	sbc_pg_t           pg_mem [MAX_TEMPLATE];
	logic [VAL_W-1:0]  dv_mem [MAX_TEMPLATE];
	sbc_pg_t           pg_rdata_q;
	logic [VAL_W-1:0]  dv_rdata_q;

	logic              pg_we;
	sbc_pg_t           pg_wdata;
	logic              dv_we;
	logic [VAL_W-1:0]  dv_wdata;
	logic [TIDX_W-1:0] dv_raddr;
	logic              hit;
	logic              at_end;

	assign hit    = (dv_rdata_q == val_q);
	assign at_end = ((TCNT_W'(idx_q) + TCNT_W'(1)) == gtot_q);

	always_comb begin
		state_d  = state_q;
		tlen_d   = tlen_q;
		gtot_d   = gtot_q;
		ovf_d    = ovf_q;
		val_d    = val_q;
		idx_d    = idx_q;
		pg_we    = 1'b0;
		pg_wdata = '{is_new: 1'b1, grp: '0};
		dv_we    = 1'b0;
		dv_wdata = value;
		dv_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.clr) begin
					tlen_d = '0;
					gtot_d = '0;
					ovf_d  = 1'b0;
				end else if (cmd.app) begin
					if (tlen_q >= TCNT_W'(MAX_TEMPLATE)) begin
						ovf_d = 1'b1;
					end else if (gtot_q == '0) begin
						// first value opens group zero without a search
						dv_we    = 1'b1;
						pg_we    = 1'b1;
						pg_wdata = '{is_new: 1'b1, grp: '0};
						gtot_d   = TCNT_W'(1);
						tlen_d   = tlen_q + TCNT_W'(1);
					end else begin
						val_d   = value;
						idx_d   = '0;
						state_d = ST_SRCH;
					end
				end
			end
			ST_SRCH: begin
				dv_raddr = idx_q + TIDX_W'(1);
				if (hit) begin
					pg_we    = 1'b1;
					pg_wdata = '{is_new: 1'b0, grp: idx_q};
					tlen_d   = tlen_q + TCNT_W'(1);
					state_d  = ST_IDLE;
				end else if (at_end) begin
					dv_we    = 1'b1;
					dv_wdata = val_q;
					pg_we    = 1'b1;
					pg_wdata = '{is_new: 1'b1, grp: gtot_q[TIDX_W-1:0]};
					gtot_d   = gtot_q + TCNT_W'(1);
					tlen_d   = tlen_q + TCNT_W'(1);
					state_d  = ST_IDLE;
				end else begin
					idx_d = idx_q + TIDX_W'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tlen_q  <= '0;
			gtot_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			tlen_q  <= tlen_d;
			gtot_q  <= gtot_d;
			ovf_q   <= ovf_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
		idx_q <= idx_d;
	end

	always_ff @(posedge clk) begin
		if (pg_we) begin
			pg_mem[tlen_q[TIDX_W-1:0]] <= pg_wdata;
		end
		pg_rdata_q <= pg_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (dv_we) begin
			dv_mem[gtot_q[TIDX_W-1:0]] <= dv_wdata;
		end
		dv_rdata_q <= dv_mem[dv_raddr];
	end

	assign pg_rdata    = pg_rdata_q;
	assign tstat.busy  = (state_q == ST_SRCH);
	assign tstat.pg_we = pg_we;
	assign tstat.ovf   = ovf_q;
	assign tstat.tlen  = tlen_q;

	a_groups_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		gtot_q <= tlen_q)
		else $error("more groups than template positions");

	a_search_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> (TCNT_W'(idx_q) < gtot_q))
		else $error("search index beyond stored groups");

endmodule

// ===== sv/sbc_letter_check.sv =====
// ----------------------------------------------------------------------------
// sbc_letter_check
// Per-letter bijection check: group-to-letter memory, letter-to-group marks,
// position count and the verdict at the end of a string.
// ----------------------------------------------------------------------------
module sbc_letter_check (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sbc_pkg::sbc_cmd_t          cmd,
	input  logic [sbc_pkg::LET_W-1:0]  letter,
	input  logic                       last_letter,
	input  sbc_pkg::sbc_tstat_t        tstat,
	input  sbc_pkg::sbc_pg_t           pg_rdata,
	output logic [sbc_pkg::TIDX_W-1:0] rd_addr,
	output logic                       ready,
	output logic                       verdict_valid,
	output sbc_pkg::sbc_out_t          verdict
);
	import sbc_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_CHK  = 1'b1;

	logic              state_q, state_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic              good_q, good_d;
	logic              fresh_q;

	logic              let_valid_q [ALPHABET_SIZE];
	logic [TIDX_W-1:0] lgm_q       [ALPHABET_SIZE];

	logic [LIDX_W-1:0] glm_mem [MAX_TEMPLATE];
	logic [LIDX_W-1:0] glm_rdata_q;

	logic [LIDX_W-1:0] let_s1;
	logic [TIDX_W-1:0] grp_s1;
	logic              new_s1;
	logic              live_s1;
	logic              bad_s1;
	logic              last_s1;

	logic              in_range;
	logic              let_ok;
	logic              conflict;
	logic              map_we;
	logic              restart;
	logic              mismatch;

	assign in_range = (pos_q < POS_W'(tstat.tlen));
	assign let_ok   = (32'(letter) < 32'(ALPHABET_SIZE));
	assign mismatch = (pos_q != POS_W'(tstat.tlen));

	always_comb begin
		state_d       = state_q;
		pos_d         = pos_q;
		good_d        = good_q;
		conflict      = 1'b0;
		map_we        = 1'b0;
		restart       = 1'b0;
		verdict_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.clr || cmd.app) begin
					restart = 1'b1;
				end else if (cmd.chk) begin
					pos_d   = (pos_q == '1) ? pos_q : pos_q + POS_W'(1);
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				if (bad_s1) begin
					conflict = 1'b1;
				end else if (live_s1) begin
					if (new_s1) begin
						conflict = let_valid_q[let_s1];
						map_we   = 1'b1;
					end else begin
						conflict = (glm_rdata_q != let_s1) || !let_valid_q[let_s1] ||
							(lgm_q[let_s1] != grp_s1);
					end
				end
				good_d = good_q & ~conflict;
				if (last_s1) begin
					verdict_valid = 1'b1;
					restart       = 1'b1;
				end
				state_d = ST_IDLE;
			end
		endcase
		if (restart) begin
			pos_d  = '0;
			good_d = 1'b1;
		end
	end

	assign verdict.matches_res       = good_q & ~conflict & ~mismatch;
	assign verdict.length_mismatch   = mismatch;
	assign verdict.template_overflow = tstat.ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			good_q  <= 1'b1;
			fresh_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			good_q  <= good_d;
			// read data matches the current position only if it held still
			fresh_q <= (pos_d == pos_q) && !tstat.pg_we;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ALPHABET_SIZE; i++) begin
				let_valid_q[i] <= 1'b0;
			end
		end else if (restart) begin
			for (int i = 0; i < ALPHABET_SIZE; i++) begin
				let_valid_q[i] <= 1'b0;
			end
		end else if (map_we) begin
			let_valid_q[let_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			lgm_q[let_s1] <= grp_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			let_s1  <= LIDX_W'(letter);
			grp_s1  <= pg_rdata.grp;
			new_s1  <= pg_rdata.is_new;
			live_s1 <= in_range & let_ok;
			bad_s1  <= in_range & ~let_ok;
			last_s1 <= last_letter;
		end
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			glm_mem[grp_s1] <= let_s1;
		end
		glm_rdata_q <= glm_mem[pg_rdata.grp];
	end

	assign rd_addr = pos_q[TIDX_W-1:0];
	assign ready   = (state_q == ST_IDLE) && fresh_q;

	a_chk_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK) |-> $past(cmd.chk))
		else $error("check stage entered without a letter item");

	a_chk_on_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.chk |-> (fresh_q && (state_q == ST_IDLE)))
		else $error("letter taken on stale position data");

endmodule

// ===== sv/string_template_bijection_check.sv =====
// ----------------------------------------------------------------------------
// string_template_bijection_check
// Checks letter strings one-to-one against a loaded numeric template.
// ----------------------------------------------------------------------------
// Load a template with append items (a clear item empties it), then stream a
// string one letter per item; the item flagged last_letter yields one result
// that says whether the string maps onto the template one-to-one, whether its
// length differs from the template's, and whether appends were dropped at
// capacity since the last clear. Any append or clear abandons a string in
// progress. A letter is taken while the group of its position is already
// read; the check state then compares the group-to-letter memory read and
// makes the map update. An append needs no search when the template is full
// or empty of groups; otherwise the distinct-value memory is read one entry a
// cycle until a match or the end. After a letter that ends a string, after an
// append that is stored, and after a clear or a dropped append that abandons a
// string in progress, the next item waits while the position memory is read
// again. A verdict that finds the output register still held waits in a skid
// entry, and no item is taken until it moves on. No clearing pass follows
// reset: the memories are read only where written since.
// ----------------------------------------------------------------------------
module string_template_bijection_check (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  sbc_pkg::sbc_in_t req,
	output logic             res_valid,
	input  logic             res_ready,
	output sbc_pkg::sbc_out_t res
);
	import sbc_pkg::*;

	sbc_cmd_t          cmd;
	sbc_tstat_t        tstat;
	sbc_pg_t           pg_rdata;
	logic [TIDX_W-1:0] rd_addr;
	logic              chk_ready;
	logic              verdict_valid;
	sbc_out_t          verdict;
	logic              accept;

	// output register plus one skid entry for a verdict that meets a stall
	logic              res_valid_q;
	sbc_out_t          res_q;
	logic              skid_valid_q;
	sbc_out_t          skid_q;
	logic              out_free;

	// hold input while the template search runs, while position data is
	// stale, or while a verdict waits in the skid entry
	assign req_ready = !tstat.busy && chk_ready && !skid_valid_q;
	assign accept    = req_valid && req_ready;

	always_comb begin
		cmd = '0;
		if (accept) begin
			unique case (req.req_type)
				REQ_CLEAR:  cmd.clr = 1'b1;
				REQ_APPEND: cmd.app = 1'b1;
				REQ_LETTER: cmd.chk = 1'b1;
				default:    cmd = '0;
			endcase
		end
	end

	sbc_tmpl_store u_tmpl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.value    (req.template_value),
		.rd_addr  (rd_addr),
		.pg_rdata (pg_rdata),
		.tstat    (tstat)
	);

	sbc_letter_check u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.letter        (req.letter),
		.last_letter   (req.last_letter),
		.tstat         (tstat),
		.pg_rdata      (pg_rdata),
		.rd_addr       (rd_addr),
		.ready         (chk_ready),
		.verdict_valid (verdict_valid),
		.verdict       (verdict)
	);

	assign out_free = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			// advance skid into the output, else take a fresh verdict
			if (skid_valid_q) begin
				res_valid_q  <= 1'b1;
				skid_valid_q <= verdict_valid;
			end else begin
				res_valid_q <= verdict_valid;
			end
		end else if (verdict_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				res_q  <= skid_q;
				skid_q <= verdict;
			end else begin
				res_q <= verdict;
			end
		end else if (verdict_valid) begin
			skid_q <= verdict;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> res_valid_q)
		else $error("skid entry filled while output register empty");

endmodule
